// ----- src/rss_pkg.sv -----
// shared types, constants and phase codes of the ramp/soak setpoint block
package rss_pkg;

    localparam int MAX_STEPS = 16;
    localparam int STEP_W    = 4;
    localparam int CNT_W     = 5;
    localparam int TIME_W    = 16;
    localparam int TEMP_W    = 11;
    localparam int NOW_W     = 22;
    localparam int MEAS_W    = 15;
    localparam int DIFF_W    = TEMP_W + 1;
    localparam int PROD_W    = TEMP_W + TIME_W;
    localparam int DIV_CNT_W = 5;

    localparam logic [1:0] PHASE_NONE = 2'd0;
    localparam logic [1:0] PHASE_RAMP = 2'd1;
    localparam logic [1:0] PHASE_HOLD = 2'd2;
    localparam logic [1:0] PHASE_PAST = 2'd3;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_EVAL  = 1'b1;

    localparam logic [TEMP_W-1:0] TEMP_MAX = {TEMP_W{1'b1}};

    typedef struct packed {
        logic                req_type;
        logic [STEP_W-1:0]   step_index;
        logic [TIME_W-1:0]   step_ramp_minutes;
        logic [TIME_W-1:0]   step_hold_minutes;
        logic [TEMP_W-1:0]   step_target_temp;
        logic [NOW_W-1:0]    elapsed_minutes;
        logic [MEAS_W-1:0]   measured_temp;
    } rss_in_t;

    typedef struct packed {
        logic [TEMP_W-1:0]   setpoint_temp;
        logic                heater_on;
        logic [STEP_W-1:0]   active_step;
        logic [1:0]          phase_kind;
    } rss_out_t;

    // step entry write broadcast to all cells
    typedef struct packed {
        logic                en;
        logic [STEP_W-1:0]   idx;
        logic [TIME_W-1:0]   ramp;
        logic [TIME_W-1:0]   hold;
        logic [TEMP_W-1:0]   tgt;
    } rss_wr_t;

    // evaluation token passed from cell to cell
    typedef struct packed {
        logic                      valid;
        logic [NOW_W-1:0]          now;
        logic [NOW_W-1:0]          acc;
        logic [TEMP_W-1:0]         prev_tgt;
        logic [CNT_W-1:0]          remaining;
        logic [STEP_W-1:0]         step;
        logic [STEP_W-1:0]         last_step;
        logic                      found;
        logic [1:0]                kind;
        logic [STEP_W-1:0]         act;
        logic [TEMP_W-1:0]         sp;
        logic                      need_div;
        logic [TEMP_W-1:0]         from;
        logic signed [DIFF_W-1:0]  diff;
        logic [TIME_W-1:0]         t;
        logic [TIME_W-1:0]         ramp;
    } rss_tok_t;

endpackage

// ----- src/rss_cell.sv -----
// one profile step: holds its entry and advances the evaluation token
module rss_cell
    import rss_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [STEP_W-1:0] cell_idx,
    input  rss_wr_t           wr,
    input  rss_tok_t          tok_in,
    output rss_tok_t          tok_out
);

    logic [TIME_W-1:0] ramp_reg;
    logic [TIME_W-1:0] hold_reg;
    logic [TEMP_W-1:0] tgt_reg;
    rss_tok_t          tok_reg;
    rss_tok_t          tok_next;
    logic [NOW_W-1:0]  rend;
    logic [NOW_W-1:0]  acc_mid;
    logic [NOW_W-1:0]  hend;

    always_ff @(posedge clk)
    begin
        if (wr.en && wr.idx == cell_idx)
        begin
            ramp_reg <= wr.ramp;
            hold_reg <= wr.hold;
            tgt_reg  <= wr.tgt;
        end
    end

    assign rend    = tok_in.acc + NOW_W'(ramp_reg);
    assign acc_mid = (ramp_reg != '0) ? rend : tok_in.acc;
    assign hend    = acc_mid + NOW_W'(hold_reg);

    always_comb
    begin
        tok_next      = tok_in;
        tok_next.step = tok_in.step + 1'b1;
        if (tok_in.valid && !tok_in.found && tok_in.remaining != '0)
        begin
            if (ramp_reg != '0 && tok_in.now <= rend)
            begin
                tok_next.found    = 1'b1;
                tok_next.kind     = PHASE_RAMP;
                tok_next.act      = tok_in.step;
                tok_next.sp       = tgt_reg;
                tok_next.need_div = (tok_in.step != '0);
                tok_next.from     = tok_in.prev_tgt;
                tok_next.diff     = $signed({1'b0, tgt_reg}) - $signed({1'b0, tok_in.prev_tgt});
                tok_next.t        = TIME_W'(tok_in.now - tok_in.acc);
                tok_next.ramp     = ramp_reg;
            end
            else if (tok_in.now <= hend)
            begin
                tok_next.found = 1'b1;
                tok_next.kind  = PHASE_HOLD;
                tok_next.act   = tok_in.step;
                tok_next.sp    = tgt_reg;
            end
            tok_next.acc       = hend;
            tok_next.remaining = tok_in.remaining - 1'b1;
            tok_next.prev_tgt  = tgt_reg;
            tok_next.last_step = tok_in.step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_reg <= '0;
        else
            tok_reg <= tok_next;
    end

    assign tok_out = tok_reg;

endmodule

// ----- src/rss_div.sv -----
// restoring divider, one quotient bit per cycle
module rss_div
    import rss_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [PROD_W-1:0] dividend,
    input  logic [TIME_W-1:0] divisor,
    output logic              done,
    output logic [PROD_W-1:0] quotient
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [TIME_W-1:0]    rem_reg;
    logic [PROD_W-1:0]    quo_reg;
    logic [TIME_W-1:0]    dvs_reg;
    logic [TIME_W:0]      rem_sh;
    logic                 fits;

    assign rem_sh = {rem_reg, quo_reg[PROD_W-1]};
    assign fits   = (rem_sh >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(PROD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? TIME_W'(rem_sh - {1'b0, dvs_reg}) : TIME_W'(rem_sh);
            quo_reg <= {quo_reg[PROD_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- src/ramp_soak_setpoint_with_heater_switch.sv -----
// top level: ramp/soak profile setpoint generator with on/off heater switch
//
// a profile of up to 16 steps lives in a row of 16 cells, one step per cell
// (ramp minutes, hold minutes, target degrees). a write word stores one step
// in the addressed cell. an evaluate word launches a token down the row: each
// cell adds its ramp and hold ends to the running minute count and latches
// the first phase that has not ended yet; the token is registered in every
// cell, then the result is collected and loaded into the output register. a
// ramp after step 0 interpolates from the previous target: a multiply
// state, a start state and a serial divide (truncating toward zero) whose
// quotient is applied to the setpoint as the divide finishes. one word is in
// work at a time; a finished result waits in the output register while the
// next word is taken. step_count is set through the cfg port (always ready)
// and saturates at 16; zero means no profile and yields setpoint 0 with the
// heater off. heater_on is set when a profile is present and measured_temp
// (1/16 degree) is below setpoint_temp.
module ramp_soak_setpoint_with_heater_switch
    import rss_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  rss_in_t          in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output rss_out_t         out_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CNT_W-1:0] cfg_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WALK  = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_START = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  sat_count;
    logic              in_accept;

    // collected result and interpolation operands
    logic [TEMP_W-1:0] sp_reg;
    logic [STEP_W-1:0] act_reg;
    logic [1:0]        kind_reg;
    logic [MEAS_W-1:0] meas_reg;
    logic [TEMP_W-1:0] from_reg;
    logic              neg_reg;
    logic [TEMP_W-1:0] mag_reg;
    logic [TIME_W-1:0] t_reg;
    logic [TIME_W-1:0] ramp_reg;
    logic [PROD_W-1:0] prod_reg;

    logic              out_valid_reg;
    rss_out_t          out_reg;

    rss_wr_t           wr;
    rss_tok_t          tok_w [0:MAX_STEPS];
    rss_tok_t          last_tok;

    logic              div_start;
    logic              div_done;
    logic [PROD_W-1:0] div_quo;
    logic signed [TEMP_W+1:0] interp;
    logic [TEMP_W-1:0] interp_sat;
    logic              out_free;

    assign cfg_ready = 1'b1;
    assign sat_count = (count_reg > CNT_W'(MAX_STEPS)) ? CNT_W'(MAX_STEPS) : count_reg;
    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cfg_valid && cfg_ready)
            count_reg <= cfg_data;
    end

    // write words go straight to the addressed cell
    assign wr.en   = in_accept && (in_data.req_type == REQ_WRITE);
    assign wr.idx  = in_data.step_index;
    assign wr.ramp = in_data.step_ramp_minutes;
    assign wr.hold = in_data.step_hold_minutes;
    assign wr.tgt  = in_data.step_target_temp;

    // token entering the first cell
    always_comb
    begin
        tok_w[0]           = '0;
        tok_w[0].valid     = in_accept && (in_data.req_type == REQ_EVAL);
        tok_w[0].now       = in_data.elapsed_minutes;
        tok_w[0].remaining = sat_count;
    end

    for (genvar g = 0; g < MAX_STEPS; g++)
    begin : g_cell
        rss_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_idx (STEP_W'(g)),
            .wr       (wr),
            .tok_in   (tok_w[g]),
            .tok_out  (tok_w[g+1])
        );
    end

    assign last_tok = tok_w[MAX_STEPS];

    assign div_start = (state_reg == S_START);

    rss_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (ramp_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // quotient magnitude never exceeds the target difference
    assign interp = neg_reg
        ? $signed({2'b00, from_reg}) - $signed({2'b00, div_quo[TEMP_W-1:0]})
        : $signed({2'b00, from_reg}) + $signed({2'b00, div_quo[TEMP_W-1:0]});
    assign interp_sat = interp[TEMP_W+1] ? '0 :
                        (interp[TEMP_W] ? TEMP_MAX : interp[TEMP_W-1:0]);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (in_accept && in_data.req_type == REQ_EVAL)
                    state_next = S_WALK;
            S_WALK:
                if (last_tok.valid)
                    state_next = (last_tok.found && last_tok.need_div) ? S_MUL : S_FIN;
            S_MUL:   state_next = S_START;
            S_START: state_next = S_DIV;
            S_DIV:
                if (div_done)
                    state_next = S_FIN;
            S_FIN:
                if (out_free)
                    state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_FIN && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            meas_reg <= in_data.measured_temp;
        if (state_reg == S_WALK && last_tok.valid)
        begin
            from_reg <= last_tok.from;
            neg_reg  <= last_tok.diff[DIFF_W-1];
            mag_reg  <= TEMP_W'(last_tok.diff[DIFF_W-1] ? -last_tok.diff : last_tok.diff);
            t_reg    <= last_tok.t;
            ramp_reg <= last_tok.ramp;
            if (last_tok.found)
            begin
                sp_reg   <= last_tok.sp;
                act_reg  <= last_tok.act;
                kind_reg <= last_tok.kind;
            end
            else if (sat_count == '0)
            begin
                sp_reg   <= '0;
                act_reg  <= '0;
                kind_reg <= PHASE_NONE;
            end
            else
            begin
                sp_reg   <= last_tok.prev_tgt;
                act_reg  <= last_tok.last_step;
                kind_reg <= PHASE_PAST;
            end
        end
        if (state_reg == S_MUL)
            prod_reg <= PROD_W'(mag_reg) * PROD_W'(t_reg);
        if (state_reg == S_DIV && div_done)
            sp_reg <= interp_sat;
        if (state_reg == S_FIN && out_free)
        begin
            out_reg.setpoint_temp <= sp_reg;
            out_reg.heater_on     <= (kind_reg != PHASE_NONE) && (meas_reg < {sp_reg, 4'b0000});
            out_reg.active_step   <= act_reg;
            out_reg.phase_kind    <= kind_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // no profile always reads as setpoint zero with the heater off
    a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.phase_kind == PHASE_NONE
        |-> out_data.setpoint_temp == '0 && !out_data.heater_on)
        else $error("no-profile result not zero");

    // past the end points at the last step in use
    a_past_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.phase_kind == PHASE_PAST
        |-> out_data.active_step == STEP_W'(sat_count - 1'b1))
        else $error("past-end result not on last step");

    // the token only leaves the row while a walk is pending
    a_tok_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        last_tok.valid |-> state_reg == S_WALK)
        else $error("token left the row outside a walk");

    // divider finishes only while it is awaited
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider done outside divide state");

endmodule
